// File: design/srac_pkg.sv
// Shared types, constants and helpers for the slant range to Cartesian converter.
package srac_pkg;

  localparam int RANGE_BITS = 24;
  localparam int ANGLE_BITS = 16;
  localparam int ROT_STAGES = 16;
  localparam int EXTRA_BITS = 32 - RANGE_BITS;

  localparam int SQ_IN_W  = 2 * RANGE_BITS + 2 * EXTRA_BITS;
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int SQ_REM_W = ROOT_W + 1;

  localparam int ANG_W   = 32;
  localparam int CX_W    = 38;
  localparam int SCALE_W = 32;
  localparam int COORD_W = 40;
  localparam int SAT_W   = 48;

  localparam int GAIN_SHIFT  = 30;
  localparam int SCALE_SHIFT = 22 + EXTRA_BITS;
  localparam int VERT_SHIFT  = 20;

  localparam logic [31:0] CORDIC_GAIN = 32'h9B74_EDA8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HSCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VSCALE = 2'd1;

  localparam logic [SCALE_W-1:0] HSCALE_RST = 32'd16777;
  localparam logic [SCALE_W-1:0] VSCALE_RST = 32'd167772;

  // accept to strobe: two front stages, root steps plus rounding, gain and
  // quadrant fold, rotation, axis swap, two scaling stages
  localparam int LATENCY = 2 + SQ_STEPS + 1 + 1 + ROT_STAGES + 1 + 2;

  localparam logic [ANG_W-1:0] ATAN_TAB [24] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2E,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
    32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
  };

  typedef struct packed {
    logic        [RANGE_BITS-1:0] slant_range;
    logic        [ANGLE_BITS-1:0] bearing;
    logic signed [RANGE_BITS-1:0] target_height;
  } srac_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] east_coord;
    logic signed [COORD_W-1:0] up_coord;
    logic signed [COORD_W-1:0] depth_coord;
    logic                      height_over_range;
  } srac_out_t;

  typedef struct packed {
    logic                      flag;
    logic        [1:0]         quad;
    logic        [ANGLE_BITS-1:0] bearing;
    logic signed [COORD_W-1:0] up;
  } srac_side_t;

  function automatic logic signed [COORD_W-1:0] sat40(input logic [SAT_W-1:0] mag,
                                                      input logic neg);
    logic [SAT_W-1:0] max_pos;
    logic [SAT_W-1:0] max_neg;
    logic [SAT_W-1:0] lim;
    logic [SAT_W-1:0] res;
    max_pos = {{(SAT_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    max_neg = {{(SAT_W-COORD_W){1'b0}}, 1'b1, {(COORD_W-1){1'b0}}};
    if (neg) begin
      lim = (mag > max_neg) ? max_neg : mag;
      res = {SAT_W{1'b0}} - lim;
    end else begin
      lim = (mag > max_pos) ? max_pos : mag;
      res = lim;
    end
    return res[COORD_W-1:0];
  endfunction

endpackage

// File: design/srac_sqrt.sv
// Pipelined digit-by-digit square root, one root bit per stage, rounded to nearest.
module srac_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [srac_pkg::SQ_IN_W-1:0] rad_i,
  input  srac_pkg::srac_side_t        side_i,
  output logic                        valid_o,
  output logic [srac_pkg::ROOT_W:0]   root_o,
  output srac_pkg::srac_side_t        side_o
);
  import srac_pkg::*;

  logic                vld_q  [SQ_STEPS];
  logic [SQ_REM_W-1:0] rem_q  [SQ_STEPS];
  logic [ROOT_W-1:0]   root_q [SQ_STEPS];
  logic [SQ_IN_W-1:0]  rad_q  [SQ_STEPS];
  srac_side_t          side_q [SQ_STEPS];

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
    logic                src_vld;
    logic [SQ_REM_W-1:0] src_rem;
    logic [ROOT_W-1:0]   src_root;
    logic [SQ_IN_W-1:0]  src_rad;
    srac_side_t          src_side;
    logic [SQ_REM_W+1:0] rem_sh;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] diff;
    logic [SQ_REM_W-1:0] rem_d;
    logic [ROOT_W-1:0]   root_d;

    if (g == 0) begin : g_first
      assign src_vld  = valid_i;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_rad  = rad_i;
      assign src_side = side_i;
    end else begin : g_next
      assign src_vld  = vld_q[g-1];
      assign src_rem  = rem_q[g-1];
      assign src_root = root_q[g-1];
      assign src_rad  = rad_q[g-1];
      assign src_side = side_q[g-1];
    end

    always_comb begin
      rem_sh = {src_rem, src_rad[SQ_IN_W-1 -: 2]};
      trial  = {1'b0, src_root, 2'b01};
      diff   = rem_sh - trial;
      if (rem_sh >= trial) begin
        rem_d  = diff[SQ_REM_W-1:0];
        root_d = {src_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[SQ_REM_W-1:0];
        root_d = {src_root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= rem_d;
      root_q[g] <= root_d;
      rad_q[g]  <= {src_rad[SQ_IN_W-3:0], 2'b00};
      side_q[g] <= src_side;
    end
  end

  logic              valid_q;
  logic [ROOT_W:0]   root_out_q;
  srac_side_t        side_out_q;
  logic [ROOT_W:0]   root_out_d;

  always_comb begin
    root_out_d = {1'b0, root_q[SQ_STEPS-1]};
    if (rem_q[SQ_STEPS-1] > {1'b0, root_q[SQ_STEPS-1]}) begin
      root_out_d = root_out_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    root_out_q <= root_out_d;
    side_out_q <= side_q[SQ_STEPS-1];
  end

  assign valid_o = valid_q;
  assign root_o  = root_out_q;
  assign side_o  = side_out_q;

endmodule

// File: design/srac_cordic.sv
// Pipelined CORDIC rotation, one micro-rotation per stage.
module srac_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [srac_pkg::CX_W-1:0] x_i,
  input  logic        [srac_pkg::ANG_W-1:0] z_i,
  input  srac_pkg::srac_side_t             side_i,
  output logic                             valid_o,
  output logic signed [srac_pkg::CX_W-1:0] x_o,
  output logic signed [srac_pkg::CX_W-1:0] y_o,
  output srac_pkg::srac_side_t             side_o
);
  import srac_pkg::*;

  logic                   vld_q  [ROT_STAGES];
  logic signed [CX_W-1:0] x_q    [ROT_STAGES];
  logic signed [CX_W-1:0] y_q    [ROT_STAGES];
  logic        [ANG_W-1:0] z_q   [ROT_STAGES];
  srac_side_t             side_q [ROT_STAGES];

  for (genvar g = 0; g < ROT_STAGES; g++) begin : g_rot
    logic                   src_vld;
    logic signed [CX_W-1:0] src_x;
    logic signed [CX_W-1:0] src_y;
    logic        [ANG_W-1:0] src_z;
    srac_side_t             src_side;
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    logic signed [CX_W-1:0] x_d;
    logic signed [CX_W-1:0] y_d;
    logic        [ANG_W-1:0] z_d;

    if (g == 0) begin : g_first
      assign src_vld  = valid_i;
      assign src_x    = x_i;
      assign src_y    = '0;
      assign src_z    = z_i;
      assign src_side = side_i;
    end else begin : g_next
      assign src_vld  = vld_q[g-1];
      assign src_x    = x_q[g-1];
      assign src_y    = y_q[g-1];
      assign src_z    = z_q[g-1];
      assign src_side = side_q[g-1];
    end

    always_comb begin
      xs = src_x >>> g;
      ys = src_y >>> g;
      if (!src_z[ANG_W-1]) begin
        x_d = src_x - ys;
        y_d = src_y + xs;
        z_d = src_z - ATAN_TAB[g];
      end else begin
        x_d = src_x + ys;
        y_d = src_y - xs;
        z_d = src_z + ATAN_TAB[g];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[g]    <= x_d;
      y_q[g]    <= y_d;
      z_q[g]    <= z_d;
      side_q[g] <= src_side;
    end
  end

  assign valid_o = vld_q[ROT_STAGES-1];
  assign x_o     = x_q[ROT_STAGES-1];
  assign y_o     = y_q[ROT_STAGES-1];
  assign side_o  = side_q[ROT_STAGES-1];

endmodule

// File: design/srac_scale.sv
// Two-stage magnitude times scale with rounding and 40-bit saturation.
module srac_scale (
  input  logic                                clk_i,
  input  logic        [srac_pkg::CX_W-1:0]    mag_i,
  input  logic                                neg_i,
  input  logic        [srac_pkg::SCALE_W-1:0] scale_i,
  output logic signed [srac_pkg::COORD_W-1:0] coord_o
);
  import srac_pkg::*;

  localparam int HALF_W = SCALE_W / 2;
  localparam int PP_W   = CX_W + HALF_W;
  localparam int SUM_W  = PP_W + 1;

  logic [PP_W-1:0]  p_hi_q;
  logic [PP_W-1:0]  p_lo_q;
  logic             neg_q;
  logic signed [COORD_W-1:0] coord_q;
  logic [SUM_W-1:0] comb;
  logic [SUM_W-1:0] rnd;
  logic [SUM_W-1:0] shifted;

  always_ff @(posedge clk_i) begin
    p_hi_q <= mag_i * scale_i[SCALE_W-1:HALF_W];
    p_lo_q <= mag_i * scale_i[HALF_W-1:0];
    neg_q  <= neg_i;
  end

  always_comb begin
    comb    = {1'b0, p_hi_q} + {{(HALF_W+1){1'b0}}, p_lo_q[PP_W-1:HALF_W]};
    rnd     = comb + (SUM_W'(1) << (SCALE_SHIFT - HALF_W - 1));
    shifted = rnd >> (SCALE_SHIFT - HALF_W);
  end

  always_ff @(posedge clk_i) begin
    coord_q <= sat40(shifted[SAT_W-1:0], neg_q);
  end

  assign coord_o = coord_q;

endmodule

// File: design/slant_range_azimuth_to_cartesian.sv
// Top level: slant range, bearing and height to scaled Cartesian coordinates.
//
//  channel   handshake           payload           width
//  input     start_i, busy_o     in_word_i         64
//  result    valid_o             result_o          121
//  config    cfg_we_i, cfg_idx_i cfg_wdata_i       32
//
// One word enters per cycle; busy_o stays low.
// Each word passes through the 32 square root steps and the 16 rotation
// stages, besides the front, gain, swap and scaling registers.
// Reset clears all valid bits and loads the default scales.
// Results are never held back: each is shown for one cycle.
module slant_range_azimuth_to_cartesian (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  srac_pkg::srac_in_t                  in_word_i,
  output logic                                valid_o,
  output srac_pkg::srac_out_t                 result_o,
  input  logic                                cfg_we_i,
  input  logic [srac_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srac_pkg::SCALE_W-1:0]        cfg_wdata_i
);
  import srac_pkg::*;

  localparam int SQ_W    = 2 * RANGE_BITS;
  localparam int VPROD_W = RANGE_BITS + SCALE_W;
  localparam int VRND_W  = VPROD_W - VERT_SHIFT + 1;
  localparam int GPROD_W = ROOT_W + 1 + 32;
  localparam int GX_W    = GPROD_W - GAIN_SHIFT;

  logic [SCALE_W-1:0] hscale_q;
  logic [SCALE_W-1:0] vscale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hscale_q <= HSCALE_RST;
      vscale_q <= VSCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HSCALE: hscale_q <= cfg_wdata_i;
        REG_VSCALE: vscale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 1: squares, compare, vertical product
  logic                  accept;
  logic                  hneg;
  logic [RANGE_BITS-1:0] habs;
  logic                  s1_vld_q;
  logic [SQ_W-1:0]       r_sq_q;
  logic [SQ_W-1:0]       h_sq_q;
  logic                  s1_flag_q;
  logic                  s1_hneg_q;
  logic [VPROD_W-1:0]    vprod_q;
  logic [ANGLE_BITS-1:0] s1_bearing_q;

  assign accept = start_i && !busy_o;

  always_comb begin
    hneg = in_word_i.target_height[RANGE_BITS-1];
    habs = hneg ? (RANGE_BITS'(0) - in_word_i.target_height) : in_word_i.target_height;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    r_sq_q       <= in_word_i.slant_range * in_word_i.slant_range;
    h_sq_q       <= habs * habs;
    s1_flag_q    <= habs > in_word_i.slant_range;
    s1_hneg_q    <= hneg;
    vprod_q      <= habs * vscale_q;
    s1_bearing_q <= in_word_i.bearing;
  end

  // stage 2: radicand and rounded height
  logic               s2_vld_q;
  logic [SQ_IN_W-1:0] rad_q;
  srac_side_t         s2_side_q;
  logic [VRND_W-1:0]  vrnd;

  always_comb begin
    vrnd = {1'b0, vprod_q[VPROD_W-1:VERT_SHIFT]} + {{(VRND_W-1){1'b0}}, vprod_q[VERT_SHIFT-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q             <= s1_flag_q ? '0 : {r_sq_q - h_sq_q, {(2*EXTRA_BITS){1'b0}}};
    s2_side_q.flag    <= s1_flag_q;
    s2_side_q.quad    <= 2'b00;
    s2_side_q.bearing <= s1_bearing_q;
    s2_side_q.up      <= sat40({{(SAT_W-VRND_W){1'b0}}, vrnd}, s1_hneg_q);
  end

  logic              sq_vld;
  logic [ROOT_W:0]   sq_root;
  srac_side_t        sq_side;

  srac_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_vld_q),
    .rad_i   (rad_q),
    .side_i  (s2_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // gain and quadrant fold
  logic [GPROD_W-1:0]     gprod;
  logic [ANG_W-1:0]       ang;
  logic [ANG_W-1:0]       ang_off;
  logic [1:0]             quad;
  srac_side_t             g_side_d;
  logic                   g_vld_q;
  logic signed [CX_W-1:0] g_x_q;
  logic [ANG_W-1:0]       g_z_q;
  srac_side_t             g_side_q;

  always_comb begin
    gprod         = sq_root * CORDIC_GAIN;
    ang           = {sq_side.bearing, {(ANG_W-ANGLE_BITS){1'b0}}};
    ang_off       = ang + 32'h2000_0000;
    quad          = ang_off[ANG_W-1 -: 2];
    g_side_d      = sq_side;
    g_side_d.quad = quad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    g_x_q    <= {{(CX_W-GX_W){1'b0}}, gprod[GPROD_W-1:GAIN_SHIFT]};
    g_z_q    <= ang - {quad, {(ANG_W-2){1'b0}}};
    g_side_q <= g_side_d;
  end

  logic                   cr_vld;
  logic signed [CX_W-1:0] cr_x;
  logic signed [CX_W-1:0] cr_y;
  srac_side_t             cr_side;

  srac_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_vld_q),
    .x_i     (g_x_q),
    .z_i     (g_z_q),
    .side_i  (g_side_q),
    .valid_o (cr_vld),
    .x_o     (cr_x),
    .y_o     (cr_y),
    .side_o  (cr_side)
  );

  // axis swap by quadrant
  logic signed [CX_W-1:0] north;
  logic signed [CX_W-1:0] east;
  logic signed [CX_W-1:0] depth;
  logic                   w_vld_q;
  logic [CX_W-1:0]        east_mag_q;
  logic                   east_neg_q;
  logic [CX_W-1:0]        depth_mag_q;
  logic                   depth_neg_q;
  logic signed [COORD_W-1:0] w_up_q;
  logic                   w_flag_q;

  always_comb begin
    case (cr_side.quad)
      2'd0: begin
        north = cr_x;
        east  = cr_y;
      end
      2'd1: begin
        north = -cr_y;
        east  = cr_x;
      end
      2'd2: begin
        north = -cr_x;
        east  = -cr_y;
      end
      default: begin
        north = cr_y;
        east  = -cr_x;
      end
    endcase
    depth = -north;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q <= 1'b0;
    end else begin
      w_vld_q <= cr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    east_neg_q  <= east[CX_W-1];
    east_mag_q  <= east[CX_W-1] ? -east : east;
    depth_neg_q <= depth[CX_W-1];
    depth_mag_q <= depth[CX_W-1] ? -depth : depth;
    w_up_q      <= cr_side.up;
    w_flag_q    <= cr_side.flag;
  end

  logic signed [COORD_W-1:0] east_coord;
  logic signed [COORD_W-1:0] depth_coord;

  srac_scale u_scale_east (
    .clk_i   (clk_i),
    .mag_i   (east_mag_q),
    .neg_i   (east_neg_q),
    .scale_i (hscale_q),
    .coord_o (east_coord)
  );

  srac_scale u_scale_depth (
    .clk_i   (clk_i),
    .mag_i   (depth_mag_q),
    .neg_i   (depth_neg_q),
    .scale_i (hscale_q),
    .coord_o (depth_coord)
  );

  // hold the pass-through fields beside the scaling stages
  logic                      sc_vld_q [2];
  logic signed [COORD_W-1:0] sc_up_q  [2];
  logic                      sc_flag_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q[0] <= 1'b0;
      sc_vld_q[1] <= 1'b0;
    end else begin
      sc_vld_q[0] <= w_vld_q;
      sc_vld_q[1] <= sc_vld_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    sc_up_q[0]   <= w_up_q;
    sc_up_q[1]   <= sc_up_q[0];
    sc_flag_q[0] <= w_flag_q;
    sc_flag_q[1] <= sc_flag_q[0];
  end

  assign valid_o                    = sc_vld_q[1];
  assign result_o.east_coord        = east_coord;
  assign result_o.up_coord          = sc_up_q[1];
  assign result_o.depth_coord       = depth_coord;
  assign result_o.height_over_range = sc_flag_q[1];

endmodule

// File: design/srac_checker.sv
// Port-level checks for the converter, bound to the top level.
module srac_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input srac_pkg::srac_in_t    in_word_i,
  input logic                  valid_o,
  input srac_pkg::srac_out_t   result_o
);
  import srac_pkg::*;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY valid_o)
    else $error("word accepted without a result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without an accepted word");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.height_over_range) |->
      (result_o.east_coord == '0 && result_o.depth_coord == '0))
    else $error("horizontal not zero under height over range");

  a_flag_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.height_over_range ==
      $past(((in_word_i.target_height[RANGE_BITS-1] ?
              (RANGE_BITS'(0) - in_word_i.target_height) :
              in_word_i.target_height) > in_word_i.slant_range), LATENCY)))
    else $error("height over range flag mismatch");

endmodule

bind slant_range_azimuth_to_cartesian srac_checker u_srac_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .in_word_i (in_word_i),
  .valid_o   (valid_o),
  .result_o  (result_o)
);

// File: test/tb_slant_range_azimuth_to_cartesian.sv
// Testbench for the slant range, bearing and height to Cartesian converter.
`timescale 1ns / 1ps

module tb_slant_range_azimuth_to_cartesian;
  import srac_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [63:0] POS_LIMIT = 64'h7F_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h80_0000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  srac_in_t in_word_i = '0;
  logic valid_o;
  srac_out_t result_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [SCALE_W-1:0] cfg_wdata_i = '0;

  logic [31:0] hscale_q = HSCALE_RST;
  logic [31:0] vscale_q = VSCALE_RST;
  srac_out_t coord_queue[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;

  slant_range_azimuth_to_cartesian u_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] root_rounded(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (v > res) res = res + 1;
    return res;
  endfunction

  function automatic logic [39:0] clip40(logic [63:0] mag, logic neg);
    logic [63:0] t;
    if (!neg) return (mag > POS_LIMIT) ? POS_LIMIT[39:0] : mag[39:0];
    t = (mag > NEG_LIMIT) ? NEG_LIMIT : mag;
    t = 64'd0 - t;
    return t[39:0];
  endfunction

  function automatic logic [39:0] scale_plane(logic [63:0] v, logic [31:0] scale);
    logic neg;
    logic [63:0] mag;
    logic [63:0] comb;
    neg = v[63];
    mag = neg ? 64'd0 - v : v;
    comb = mag * {48'd0, scale[31:16]} + ((mag * {48'd0, scale[15:0]}) >> 16);
    comb = (comb + (64'd1 << (SCALE_SHIFT - 17))) >> (SCALE_SHIFT - 16);
    return clip40(comb, neg);
  endfunction

  function automatic srac_out_t predict_coords(srac_in_t w);
    srac_out_t o;
    logic [63:0] rng, habs, hq, x, y, xs, ys, east, north, m;
    logic [31:0] ang, z;
    logic [1:0] quad;
    logic hneg;
    rng = {40'd0, w.slant_range};
    hneg = w.target_height[RANGE_BITS-1];
    habs = {40'd0, hneg ? -w.target_height : w.target_height};
    hq = 0;
    o.height_over_range = habs > rng;
    if (!o.height_over_range) hq = root_rounded((rng * rng - habs * habs) << (2 * EXTRA_BITS));
    x = (hq * {32'd0, CORDIC_GAIN}) >> GAIN_SHIFT;
    y = 0;
    ang = {w.bearing, 16'd0};
    quad = 2'((ang + 32'h2000_0000) >> 30);
    z = ang - ({30'd0, quad} << 30);
    for (int i = 0; i < ROT_STAGES; i++) begin
      xs = $signed(x) >>> i;
      ys = $signed(y) >>> i;
      if (!z[31]) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[i];
      end
    end
    case (quad)
      2'd0: begin north = x; east = y; end
      2'd1: begin north = 64'd0 - y; east = x; end
      2'd2: begin north = 64'd0 - x; east = 64'd0 - y; end
      default: begin north = y; east = 64'd0 - x; end
    endcase
    o.east_coord = scale_plane(east, hscale_q);
    m = habs * {32'd0, vscale_q};
    o.up_coord = clip40((m + (64'd1 << (VERT_SHIFT - 1))) >> VERT_SHIFT, hneg);
    o.depth_coord = scale_plane(64'd0 - north, hscale_q);
    return o;
  endfunction

  task automatic send_word(srac_in_t w);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy_o);
    coord_queue.push_back(predict_coords(w));
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (coord_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_scales(logic [31:0] hs, logic [31:0] vs);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= $urandom_range(0, 1) ? REG_SPARE : REG_TOP;
    cfg_wdata_i <= $urandom;
    @(posedge clk_i);
    cfg_idx_i <= REG_HSCALE;
    cfg_wdata_i <= hs;
    @(posedge clk_i);
    cfg_idx_i <= REG_VSCALE;
    cfg_wdata_i <= vs;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hscale_q = hs;
    vscale_q = vs;
  endtask

  function automatic srac_in_t make_word(logic [23:0] r, logic [15:0] b, logic [23:0] h);
    srac_in_t w;
    w.slant_range = r;
    w.bearing = b;
    w.target_height = h;
    return w;
  endfunction

  function automatic srac_in_t random_word();
    logic [23:0] r, h;
    r = 24'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      h = 24'($urandom_range(0, r));
      if ($urandom_range(0, 1)) h = -h;
    end else begin
      h = 24'($urandom);
    end
    if ($urandom_range(0, 7) == 0) r = 24'($urandom_range(0, 4095));
    return make_word(r, 16'($urandom), h);
  endfunction

  task automatic test_directed();
    logic [15:0] bearings[8] = '{16'h0000, 16'h2000, 16'h4000, 16'h8000,
                                 16'hC000, 16'hFFFF, 16'h1FFF, 16'h6000};
    foreach (bearings[i]) send_word(make_word(24'hFF_FFFF, bearings[i], 24'd0));
    send_word(make_word(24'd0, 16'd0, 24'd0));
    send_word(make_word(24'd100, 16'h1234, 24'd101));
    send_word(make_word(24'd100, 16'h1234, -24'd101));
    send_word(make_word(24'd5000, 16'hABCD, 24'd5000));
    send_word(make_word(24'hFF_FFFF, 16'h5555, 24'h80_0000));
    send_word(make_word(24'hFF_FFFF, 16'hAAAA, 24'h7F_FFFF));
    send_word(make_word(24'd1, 16'h7FFF, 24'd0));
  endtask

  task automatic test_scale_extremes();
    write_scales(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(make_word(24'hFF_FFFF, 16'h2000, 24'h80_0000));
    send_word(make_word(24'hFF_FFFF, 16'hA000, 24'h7F_FFFF));
    send_word(make_word(24'hFF_FFFF, 16'hE000, 24'd0));
    write_scales(32'd0, 32'd0);
    send_word(make_word(24'hFF_FFFF, 16'h3000, 24'h12_3456));
    write_scales(32'd1, 32'd1);
    send_word(make_word(24'hFF_FFFF, 16'h9000, 24'h80_0000));
    write_scales(HSCALE_RST, VSCALE_RST);
  endtask

  task automatic test_random(int n);
    repeat (n) send_word(random_word());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (coord_queue.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        srac_out_t e;
        e = coord_queue.pop_front();
        if (result_o.east_coord !== e.east_coord) begin
          $error("east_coord exp %0d got %0d", e.east_coord, result_o.east_coord);
          errors++;
        end
        if (result_o.up_coord !== e.up_coord) begin
          $error("up_coord exp %0d got %0d", e.up_coord, result_o.up_coord);
          errors++;
        end
        if (result_o.depth_coord !== e.depth_coord) begin
          $error("depth_coord exp %0d got %0d", e.depth_coord, result_o.depth_coord);
          errors++;
        end
        if (result_o.height_over_range !== e.height_over_range) begin
          $error("height_over_range exp %0d got %0d", e.height_over_range,
                 result_o.height_over_range);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (valid_o || (start_i && !busy_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_scale_extremes();
    test_random(300);
    write_scales($urandom, $urandom_range(1, 32'h0200_0000));
    test_random(300);
    write_scales($urandom_range(1, 32'h0100_0000), $urandom);
    gaps_on = 1'b0;
    test_random(300);
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: slant_range_azimuth_to_cartesian.f
design/srac_pkg.sv
design/srac_sqrt.sv
design/srac_cordic.sv
design/srac_scale.sv
design/slant_range_azimuth_to_cartesian.sv
design/srac_checker.sv
test/tb_slant_range_azimuth_to_cartesian.sv
